@@ sv/rsc_pkg.sv @@
// Shared types, widths and codes for the RPN stack calculator.
`timescale 1ns / 1ps

package rsc_pkg;

	localparam int DEPTH     = 256;
	localparam int WORD_W    = 32;
	localparam int CMD_W     = 3;
	localparam int IDX_W     = 8;
	localparam int STAT_W    = 3;
	localparam int DEPTH_W   = 9;
	localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int CMP_W     = (CNT_W > IDX_W) ? CNT_W : IDX_W;
	localparam int DIV_ITER_W = $clog2(WORD_W);

	typedef logic [CMD_W-1:0]          cmd_t;
	typedef logic signed [WORD_W-1:0]  word_t;
	typedef logic [IDX_W-1:0]          index_t;
	typedef logic [STAT_W-1:0]         status_t;
	typedef logic [DEPTH_W-1:0]        depth_t;
	typedef logic [ADDR_W-1:0]         addr_t;
	typedef logic [CNT_W-1:0]          count_t;

	localparam count_t CNT_FULL = CNT_W'(DEPTH);

	localparam cmd_t CMD_PUSH    = 3'd0;
	localparam cmd_t CMD_POP     = 3'd1;
	localparam cmd_t CMD_ADD     = 3'd2;
	localparam cmd_t CMD_SUB     = 3'd3;
	localparam cmd_t CMD_MUL     = 3'd4;
	localparam cmd_t CMD_DIV     = 3'd5;
	localparam cmd_t CMD_RD_TOP  = 3'd6;
	localparam cmd_t CMD_RD_BOT  = 3'd7;

	localparam status_t STAT_OK      = 3'd0;
	localparam status_t STAT_EMPTY   = 3'd1;
	localparam status_t STAT_RANGE   = 3'd2;
	localparam status_t STAT_FEW     = 3'd3;
	localparam status_t STAT_DIVZERO = 3'd4;
	localparam status_t STAT_FULL    = 3'd5;

endpackage

@@ sv/rpn_stack_calculator.sv @@
// Top level of the RPN stack calculator: command sequencer, stack count and result register.
`timescale 1ns / 1ps

// Postfix stack calculator taking one command word at a time on the input channel and
// returning one result word (value, status, depth after the command) on the output
// channel. The stack lives in a single RAM with one write port and one registered read
// port, so operands are fetched one per cycle. A new command is taken only once the
// previous one has finished. Divide uses the one-bit-per-cycle divider (32 steps
// plus a sign fix-up). A result waits in the output register while the next command
// is taken; the sequencer only holds when it has a new result and the previous one is
// still stalled. Stack entries are undefined after reset, and only entries below the
// count are ever read, so no clearing pass is needed.
module rpn_stack_calculator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  rsc_pkg::cmd_t     command,
	input  rsc_pkg::word_t    push_value,
	input  rsc_pkg::index_t   entry_index,
	output logic              out_valid,
	input  logic              out_stall,
	output rsc_pkg::word_t    value_out,
	output rsc_pkg::status_t  status,
	output rsc_pkg::depth_t   depth_now
);
	import rsc_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_RDW    = 4'd2;  // wait for a single read, then report it
	localparam logic [3:0] S_RDB    = 4'd3;  // top operand arrives
	localparam logic [3:0] S_RDA    = 4'd4;  // second operand arrives
	localparam logic [3:0] S_DIV    = 4'd5;
	localparam logic [3:0] S_WB     = 4'd6;
	localparam logic [3:0] S_OUT    = 4'd7;

	logic [3:0] state_q, state_d;
	count_t     count_q, count_d;
	logic       out_valid_q;

	// latched command word
	cmd_t    cmd_q;
	word_t   pv_q;
	index_t  idx_q;

	// operand, result and pending report
	word_t   b_q, b_d;
	word_t   res_q, res_d;
	word_t   fin_val_q, fin_val_d;
	status_t fin_stat_q, fin_stat_d;

	word_t   value_q;
	status_t status_q;
	depth_t  depth_q;

	logic    ram_we;
	addr_t   ram_waddr;
	word_t   ram_wdata;
	addr_t   ram_raddr;
	word_t   ram_rdata;

	logic    div_start;
	logic    div_done;
	word_t   div_quot;

	logic    in_take;
	logic    out_free;
	logic    out_load;

	count_t           cnt_m1;
	count_t           cnt_m2;
	logic [CMP_W-1:0] cnt_ext;
	logic [CMP_W-1:0] idx_ext;
	logic [CMP_W-1:0] top_pos;
	logic [2*WORD_W-1:0] prod;

	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign cnt_m1  = count_q - CNT_W'(1);
	assign cnt_m2  = count_q - CNT_W'(2);
	assign cnt_ext = CMP_W'(count_q);
	assign idx_ext = CMP_W'(idx_q);
	assign top_pos = cnt_ext - idx_ext - CMP_W'(1);
	assign prod    = ram_rdata * b_q;

	rsc_stack_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rsc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ram_rdata),
		.divisor  (b_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		b_d        = b_q;
		res_d      = res_q;
		fin_val_d  = fin_val_q;
		fin_stat_d = fin_stat_q;
		ram_we     = 1'b0;
		ram_waddr  = count_q[ADDR_W-1:0];
		ram_wdata  = pv_q;
		ram_raddr  = cnt_m1[ADDR_W-1:0];
		div_start  = 1'b0;
		out_load   = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (in_take) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				fin_val_d  = '0;
				fin_stat_d = STAT_OK;
				case (cmd_q)
					CMD_PUSH: begin
						state_d = S_OUT;
						if (count_q == CNT_FULL) begin
							fin_stat_d = STAT_FULL;
						end else begin
							ram_we    = 1'b1;
							count_d   = count_q + CNT_W'(1);
							fin_val_d = pv_q;
						end
					end
					CMD_POP: begin
						if (count_q == '0) begin
							fin_stat_d = STAT_EMPTY;
							state_d    = S_OUT;
						end else begin
							count_d = cnt_m1;
							state_d = S_RDW;
						end
					end
					CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
						// leave the stack alone when there are not two operands
						if (count_q <= CNT_W'(1)) begin
							fin_stat_d = STAT_FEW;
							state_d    = S_OUT;
						end else begin
							state_d = S_RDB;
						end
					end
					CMD_RD_TOP, CMD_RD_BOT: begin
						ram_raddr = (cmd_q == CMD_RD_TOP) ? top_pos[ADDR_W-1:0]
						                                  : idx_ext[ADDR_W-1:0];
						if (idx_ext >= cnt_ext) begin
							fin_stat_d = STAT_RANGE;
							state_d    = S_OUT;
						end else begin
							state_d = S_RDW;
						end
					end
					default: begin
						state_d = S_OUT;
					end
				endcase
			end
			S_RDW: begin
				fin_val_d = ram_rdata;
				state_d   = S_OUT;
			end
			S_RDB: begin
				b_d       = ram_rdata;
				ram_raddr = cnt_m2[ADDR_W-1:0];
				state_d   = S_RDA;
			end
			S_RDA: begin
				// both operands are off the stack from here on
				count_d = cnt_m2;
				case (cmd_q)
					CMD_ADD: begin
						res_d   = ram_rdata + b_q;
						state_d = S_WB;
					end
					CMD_SUB: begin
						res_d   = ram_rdata - b_q;
						state_d = S_WB;
					end
					CMD_MUL: begin
						res_d   = word_t'(prod[WORD_W-1:0]);
						state_d = S_WB;
					end
					default: begin
						if (b_q == '0) begin
							fin_stat_d = STAT_DIVZERO;
							state_d    = S_OUT;
						end else begin
							div_start = 1'b1;
							state_d   = S_DIV;
						end
					end
				endcase
			end
			S_DIV: begin
				if (div_done) begin
					res_d   = div_quot;
					state_d = S_WB;
				end
			end
			S_WB: begin
				ram_we    = 1'b1;
				ram_wdata = res_q;
				count_d   = count_q + CNT_W'(1);
				fin_val_d = res_q;
				state_d   = S_OUT;
			end
			S_OUT: begin
				// hold until the previous result word has been taken
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_q <= command;
			pv_q  <= push_value;
			idx_q <= entry_index;
		end
		b_q        <= b_d;
		res_q      <= res_d;
		fin_val_q  <= fin_val_d;
		fin_stat_q <= fin_stat_d;
		if (out_load) begin
			value_q  <= fin_val_q;
			status_q <= fin_stat_q;
			depth_q  <= DEPTH_W'(count_q);
		end
	end

	assign out_valid = out_valid_q;
	assign value_out = value_q;
	assign status    = status_q;
	assign depth_now = depth_q;

endmodule

@@ sv/rsc_stack_ram.sv @@
// Stack storage: one write port and one registered read port.
`timescale 1ns / 1ps

module rsc_stack_ram (
	input  logic           clk,
	input  logic           we,
	input  rsc_pkg::addr_t waddr,
	input  rsc_pkg::word_t wdata,
	input  rsc_pkg::addr_t raddr,
	output rsc_pkg::word_t rdata
);
	import rsc_pkg::*;

	word_t mem [DEPTH];
	word_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/rsc_divider.sv @@
// Iterative signed floor divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module rsc_divider (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  rsc_pkg::word_t dividend,
	input  rsc_pkg::word_t divisor,
	output logic           done,
	output rsc_pkg::word_t quotient
);
	import rsc_pkg::*;

	localparam logic [DIV_ITER_W-1:0] LAST_ITER = DIV_ITER_W'(WORD_W - 1);

	logic                  busy_q;
	logic                  fix_q;
	logic                  done_q;
	logic [DIV_ITER_W-1:0] iter_q;
	logic [WORD_W-1:0]     rem_q;
	logic [WORD_W-1:0]     quo_q;
	logic [WORD_W-1:0]     dvs_q;
	logic                  neg_q;
	word_t                 quotient_q;

	logic [WORD_W:0]       rem_sh;
	logic [WORD_W:0]       rem_sub;
	logic                  ge;

	assign rem_sh  = {rem_q, quo_q[WORD_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign ge      = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == LAST_ITER) begin
					busy_q <= 1'b0;
					fix_q  <= 1'b1;
				end
			end else if (fix_q) begin
				fix_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// magnitudes in, restoring steps, then sign and floor fix-up
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
			quo_q <= dividend[WORD_W-1] ? WORD_W'(-dividend) : WORD_W'(dividend);
			dvs_q <= divisor[WORD_W-1] ? WORD_W'(-divisor) : WORD_W'(divisor);
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
			quo_q <= {quo_q[WORD_W-2:0], ge};
		end else if (fix_q) begin
			// -q - 1 is ~q when signs differ and something is left over
			if (neg_q) begin
				quotient_q <= (rem_q != '0) ? word_t'(~quo_q) : word_t'(-quo_q);
			end else begin
				quotient_q <= word_t'(quo_q);
			end
		end
	end

	assign done     = done_q;
	assign quotient = quotient_q;

endmodule
